>>> design/route_table_prefix_match_core_macros.svh
// Assertion macros for the route table core.
// Used by rtpm_ctrl and rtpm_dp; expects clk_i and rst_ni in scope.
`ifndef ROUTE_TABLE_PREFIX_MATCH_CORE_MACROS_SVH
`define ROUTE_TABLE_PREFIX_MATCH_CORE_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define RTPM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define RTPM_ASSERT_NEVER(name, cond, msg) \
  `RTPM_ASSERT(name, !(cond), msg)

`endif

>>> design/rtpm_pkg.sv
// Shared constants and types for the route table core.
// No dependencies; used by every module of the block.
package rtpm_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned AddrW        = 32;
  localparam int unsigned IdxW         = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW         = $clog2(TableEntries + 1);
  localparam int unsigned LenW         = $clog2(AddrW + 1);

  localparam logic ModeAdd      = 1'b0;
  localparam logic ModeLookup   = 1'b1;
  localparam logic StatusStored = 1'b0;
  localparam logic StatusFull   = 1'b1;

  typedef struct packed {
    logic [AddrW-1:0] network;
    logic [AddrW-1:0] mask;
    logic [AddrW-1:0] gateway;
    logic [LenW-1:0]  len;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept_add;
    logic accept_lookup;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic drained;
  } dp_status_t;

endpackage

>>> design/rtpm_ctrl.sv
// Controller state machine for the route table core.
// Depends on rtpm_pkg and the assertion macro header.
`include "route_table_prefix_match_core_macros.svh"

module rtpm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   mode_i,
  input  rtpm_pkg::dp_status_t   status_i,
  output rtpm_pkg::ctrl_cmd_t    cmd_o,
  output logic                   busy_o,
  output logic                   valid_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          if (mode_i == rtpm_pkg::ModeLookup) begin
            cmd_o.accept_lookup = 1'b1;
            state_d             = StScan;
          end else begin
            cmd_o.accept_add = 1'b1;
            state_d          = StDone;
          end
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (status_i.drained) begin
          cmd_o.finish = 1'b1;
          state_d      = StDone;
        end
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o  = (state_q != StIdle);
  assign valid_o = (state_q == StDone);

  `RTPM_ASSERT(a_done_one_cycle, (state_q == StDone) |=> (state_q == StIdle), "result strobe held")
  `RTPM_ASSERT(a_lookup_scans, (start_i && !busy_o && mode_i == rtpm_pkg::ModeLookup) |=> (state_q == StScan), "lookup did not start scan")
  `RTPM_ASSERT(a_add_one_result, (start_i && !busy_o && mode_i == rtpm_pkg::ModeAdd) |=> valid_o, "add result missing")

endmodule

>>> design/rtpm_dp.sv
// Datapath of the route table core: entry store, scan pointer, best-match
// registers and result registers. Depends on rtpm_pkg and the macro header.
`include "route_table_prefix_match_core_macros.svh"

module rtpm_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rtpm_pkg::ctrl_cmd_t                cmd_i,
  output rtpm_pkg::dp_status_t               status_o,
  input  logic [rtpm_pkg::AddrW-1:0]         address_i,
  input  logic [rtpm_pkg::AddrW-1:0]         mask_i,
  input  logic [rtpm_pkg::AddrW-1:0]         gateway_addr_i,
  output logic                               status_bit_o,
  output logic                               route_found_o,
  output logic [rtpm_pkg::AddrW-1:0]         hop_addr_o
);

  // Population count: per-byte counts, then one add of four.
  function automatic logic [rtpm_pkg::LenW-1:0] ones32(input logic [31:0] v);
    logic [3:0]                byte_cnt [4];
    logic [rtpm_pkg::LenW-1:0] sum;
    sum = '0;
    for (int b = 0; b < 4; b++) begin
      byte_cnt[b] = '0;
      for (int k = 0; k < 8; k++) begin
        byte_cnt[b] = byte_cnt[b] + {3'b000, v[8*b+k]};
      end
    end
    for (int b = 0; b < 4; b++) begin
      sum = sum + {{(rtpm_pkg::LenW-4){1'b0}}, byte_cnt[b]};
    end
    return sum;
  endfunction

  rtpm_pkg::entry_t mem_q [rtpm_pkg::TableEntries];
  rtpm_pkg::entry_t rd_q;
  rtpm_pkg::entry_t wr_entry;

  logic [rtpm_pkg::CntW-1:0]  count_q, count_d;
  logic [rtpm_pkg::CntW-1:0]  idx_q, idx_d;
  logic                       pend_q, pend_d;
  logic                       hit_q, hit_d;
  logic [rtpm_pkg::LenW-1:0]  best_len_q, best_len_d;
  logic [rtpm_pkg::AddrW-1:0] best_gw_q, best_gw_d;
  logic [rtpm_pkg::AddrW-1:0] addr_q;
  logic                       full;
  logic                       issue;
  logic                       match;
  logic                       status_q;
  logic                       found_q;
  logic [rtpm_pkg::AddrW-1:0] hop_q;

  assign full  = (count_q == rtpm_pkg::CntW'(rtpm_pkg::TableEntries));
  assign issue = cmd_i.scan && (idx_q != count_q);
  assign match = ((addr_q & rd_q.mask) == rd_q.network);

  assign status_o.drained = (idx_q == count_q) && !pend_q;

  assign wr_entry.network = address_i & mask_i;
  assign wr_entry.mask    = mask_i;
  assign wr_entry.gateway = gateway_addr_i;
  assign wr_entry.len     = ones32(mask_i);

  // Entries fill in order and are never freed, so the valid ones are
  // exactly indexes below count_q.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_add && !full) begin
      mem_q[count_q[rtpm_pkg::IdxW-1:0]] <= wr_entry;
    end
    if (issue) begin
      rd_q <= mem_q[idx_q[rtpm_pkg::IdxW-1:0]];
    end
  end

  always_comb begin
    count_d    = count_q;
    idx_d      = idx_q;
    pend_d     = issue;
    hit_d      = hit_q;
    best_len_d = best_len_q;
    best_gw_d  = best_gw_q;
    if (cmd_i.accept_add && !full) begin
      count_d = count_q + 1'b1;
    end
    if (cmd_i.accept_lookup) begin
      idx_d = '0;
      hit_d = 1'b0;
    end else if (issue) begin
      idx_d = idx_q + 1'b1;
    end
    // strict > keeps the earliest entry on equal prefix length
    if (pend_q && match && (!hit_q || rd_q.len > best_len_q)) begin
      hit_d      = 1'b1;
      best_len_d = rd_q.len;
      best_gw_d  = rd_q.gateway;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_len_q <= best_len_d;
    best_gw_q  <= best_gw_d;
    if (cmd_i.accept_lookup) begin
      addr_q <= address_i;
    end
    if (cmd_i.accept_add) begin
      status_q <= full ? rtpm_pkg::StatusFull : rtpm_pkg::StatusStored;
      found_q  <= 1'b0;
      hop_q    <= '0;
    end else if (cmd_i.finish) begin
      status_q <= rtpm_pkg::StatusStored;
      found_q  <= hit_q;
      if (!hit_q) begin
        hop_q <= '0;
      end else if (best_gw_q == '0) begin
        hop_q <= addr_q;
      end else begin
        hop_q <= best_gw_q;
      end
    end
  end

  assign status_bit_o  = status_q;
  assign route_found_o = found_q;
  assign hop_addr_o    = hop_q;

  `RTPM_ASSERT_NEVER(a_count_bound, count_q > rtpm_pkg::CntW'(rtpm_pkg::TableEntries), "fill count past table size")
  `RTPM_ASSERT_NEVER(a_idx_bound, idx_q > count_q, "scan pointer past fill count")
  `RTPM_ASSERT(a_full_keeps, (cmd_i.accept_add && full) |=> $stable(count_q), "add to full table changed count")

endmodule

>>> design/route_table_prefix_match_core.sv
// Top level of the route table core: controller plus datapath.
// Depends on rtpm_pkg, rtpm_ctrl and rtpm_dp.
//
// Usage:
//   A request is taken at a rising edge with start_i high and busy_o low.
//   mode_i = 0 adds a route (address, mask, gateway) in the next free entry;
//   mode_i = 1 looks up address_i by longest prefix (most mask one-bits,
//   earliest entry on a tie).
//   Each request gives exactly one result, shown on status_o, route_found_o
//   and hop_addr_o for one cycle with valid_o high. The receiver cannot
//   stall; it must take the result in that cycle.
//   An add goes from idle straight to its result state, so busy_o is high
//   only in its result cycle. A lookup walks the filled entries (at most
//   TableEntries) one per cycle through the entry store's single registered
//   read port, then finishes the last compare before its result state.
//   Between requests: busy_o drops right after the result cycle and the next
//   request is taken at the end of the following cycle, so a new request is
//   only taken once the last one has given its result.
//   Reset empties the table (fill count to zero) at once; no clearing pass.
module route_table_prefix_match_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       mode_i,
  input  logic [rtpm_pkg::AddrW-1:0] address_i,
  input  logic [rtpm_pkg::AddrW-1:0] mask_i,
  input  logic [rtpm_pkg::AddrW-1:0] gateway_addr_i,
  output logic                       valid_o,
  output logic                       status_o,
  output logic                       route_found_o,
  output logic [rtpm_pkg::AddrW-1:0] hop_addr_o
);

  rtpm_pkg::ctrl_cmd_t  cmd;
  rtpm_pkg::dp_status_t dp_status;

  rtpm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .mode_i   (mode_i),
    .status_i (dp_status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .valid_o  (valid_o)
  );

  rtpm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .address_i      (address_i),
    .mask_i         (mask_i),
    .gateway_addr_i (gateway_addr_i),
    .status_bit_o   (status_o),
    .route_found_o  (route_found_o),
    .hop_addr_o     (hop_addr_o)
  );

endmodule

>>> tb/route_table_prefix_match_checker.sv
`timescale 1ns / 1ps
// Checker for the route table core: watches requests and results, predicts each result.
// Depends on rtpm_pkg; instantiated beside the core by route_table_prefix_match_core_tb.
module route_table_prefix_match_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic                       mode_i,
  input  logic [rtpm_pkg::AddrW-1:0] address_i,
  input  logic [rtpm_pkg::AddrW-1:0] mask_i,
  input  logic [rtpm_pkg::AddrW-1:0] gateway_addr_i,
  input  logic                       valid_i,
  input  logic                       status_i,
  input  logic                       route_found_i,
  input  logic [rtpm_pkg::AddrW-1:0] hop_addr_i,
  output int                         errors_o,
  output int                         pending_o
);
  import rtpm_pkg::*;

  typedef struct packed {
    logic             status;
    logic             found;
    logic [AddrW-1:0] hop;
  } route_result_t;

  logic             route_valid   [TableEntries];
  logic [AddrW-1:0] route_network [TableEntries];
  logic [AddrW-1:0] route_mask    [TableEntries];
  logic [AddrW-1:0] route_gateway [TableEntries];

  route_result_t expected_routes[$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  task automatic report_mismatch(input string what, input logic [AddrW-1:0] got,
                                 input logic [AddrW-1:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
    errors_o++;
  endtask

  // Updates the table copy and returns what the core must answer.
  function automatic route_result_t predict_request(input logic mode,
                                                    input logic [AddrW-1:0] addr,
                                                    input logic [AddrW-1:0] msk,
                                                    input logic [AddrW-1:0] gw);
    route_result_t res;
    logic          hit;
    int            best_len;
    res      = '0;
    hit      = 1'b0;
    best_len = 0;
    if (mode == ModeAdd) begin
      res.status = StatusFull;
      for (int i = 0; i < TableEntries; i++) begin
        if (!route_valid[i]) begin
          route_valid[i]   = 1'b1;
          route_network[i] = addr & msk;
          route_mask[i]    = msk;
          route_gateway[i] = gw;
          res.status       = StatusStored;
          break;
        end
      end
    end else begin
      // strict compare keeps the earliest entry on equal prefix length
      for (int i = 0; i < TableEntries; i++) begin
        if (route_valid[i] && ((addr & route_mask[i]) == route_network[i]) &&
            (!hit || $countones(route_mask[i]) > best_len)) begin
          hit      = 1'b1;
          best_len = $countones(route_mask[i]);
          res.hop  = (route_gateway[i] == '0) ? addr : route_gateway[i];
        end
      end
      res.found = hit;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    route_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TableEntries; i++) route_valid[i] = 1'b0;
      expected_routes.delete();
    end else begin
      if (valid_i === 1'b1) begin
        if (expected_routes.size() == 0) begin
          // result strobe with no request outstanding
          report_mismatch("valid", AddrW'(1), '0);
        end else begin
          want = expected_routes.pop_front();
          if (status_i !== want.status)
            report_mismatch("status", AddrW'(status_i), AddrW'(want.status));
          if (route_found_i !== want.found)
            report_mismatch("route_found", AddrW'(route_found_i), AddrW'(want.found));
          if (hop_addr_i !== want.hop)
            report_mismatch("hop_addr", hop_addr_i, want.hop);
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0)
        expected_routes.push_back(predict_request(mode_i, address_i, mask_i, gateway_addr_i));
    end
    pending_o = expected_routes.size();
  end

endmodule

>>> tb/route_table_prefix_match_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for route_table_prefix_match_core: clock, reset, request stimulus, verdict.
// Depends on rtpm_pkg, the core and route_table_prefix_match_checker.
module route_table_prefix_match_core_tb;
  import rtpm_pkg::*;

  localparam int RandomRequests = 1000;
  localparam int DrainCycles    = 30;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic             mode_i;
  logic [AddrW-1:0] address_i;
  logic [AddrW-1:0] mask_i;
  logic [AddrW-1:0] gateway_addr_i;
  logic             valid_o;
  logic             status_o;
  logic             route_found_o;
  logic [AddrW-1:0] hop_addr_o;
  int               errors;
  int               pending;

  // routes the core is known to hold, for aiming lookups at them
  logic [AddrW-1:0] held_network[$];
  logic [AddrW-1:0] held_mask[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  route_table_prefix_match_core i_dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .mode_i,
    .address_i,
    .mask_i,
    .gateway_addr_i,
    .valid_o,
    .status_o,
    .route_found_o,
    .hop_addr_o
  );

  route_table_prefix_match_checker i_checker (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_i        (busy_o),
    .mode_i,
    .address_i,
    .mask_i,
    .gateway_addr_i,
    .valid_i       (valid_o),
    .status_i      (status_o),
    .route_found_i (route_found_o),
    .hop_addr_i    (hop_addr_o),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  // Holds start high until the request is taken; idles first with the given odds.
  task automatic send_request(input logic mode, input logic [AddrW-1:0] addr,
                              input logic [AddrW-1:0] msk, input logic [AddrW-1:0] gw,
                              input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i        <= 1'b0;
      mode_i         <= 1'($urandom);
      address_i      <= $urandom;
      mask_i         <= $urandom;
      gateway_addr_i <= $urandom;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    mode_i         <= mode;
    address_i      <= addr;
    mask_i         <= msk;
    gateway_addr_i <= gw;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  task automatic add_route(input logic [AddrW-1:0] addr, input logic [AddrW-1:0] msk,
                           input logic [AddrW-1:0] gw, input int idle_pct);
    if (held_network.size() < TableEntries) begin
      held_network.push_back(addr & msk);
      held_mask.push_back(msk);
    end
    send_request(ModeAdd, addr, msk, gw, idle_pct);
  endtask

  task automatic lookup(input logic [AddrW-1:0] addr, input int idle_pct);
    send_request(ModeLookup, addr, $urandom, $urandom, idle_pct);
  endtask

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int               idle_pct;
    int               pick;
    int               len;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] msk;
    logic [AddrW-1:0] gw;
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    mode_i         <= ModeAdd;
    address_i      <= '0;
    mask_i         <= '0;
    gateway_addr_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, prefix lengths, direct delivery, default route,
    // ties, scattered mask bits, duplicates and a host route
    lookup(32'hFFFF_FFFF, 36);
    add_route(32'hC0A8_0155, 32'hFFFF_FF00, 32'h0A00_0001, 36);
    add_route(32'hC0A8_0000, 32'hFFFF_0000, 32'h0000_0000, 36);
    lookup(32'hC0A8_01FE, 36);
    lookup(32'hC0A8_FF01, 36);
    lookup(32'h0000_0000, 36);
    add_route(32'hDEAD_BEEF, 32'h0000_0000, 32'hFFFF_FFFF, 36);
    lookup(32'h0102_0304, 36);
    lookup(32'h0000_0000, 36);
    add_route(32'h0A00_0000, 32'hFF00_0000, 32'h1111_1111, 36);
    add_route(32'h000A_0000, 32'h00FF_0000, 32'h2222_2222, 36);
    lookup(32'h0A0A_0000, 36);
    add_route(32'h8000_0001, 32'h8000_0001, 32'h3333_3333, 36);
    add_route(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h4444_4444, 36);
    lookup(32'hAAAA_AAAB, 36);
    lookup(32'h8000_0001, 36);
    add_route(32'hC0A8_0155, 32'hFFFF_FF00, 32'h5555_5555, 36);
    lookup(32'hC0A8_0101, 36);
    add_route(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 36);
    lookup(32'hFFFF_FFFF, 36);
    lookup(32'h5555_5555, 36);

    for (int n = 0; n < RandomRequests; n++) begin
      if (n < RandomRequests / 3)          idle_pct = 36;
      else if (n < 2 * RandomRequests / 3) idle_pct = 84;
      else                                 idle_pct = 0;
      if ($urandom_range(99) < 20) begin
        case ($urandom_range(3))
          0: msk = $urandom;
          3: msk = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
          default: begin
            len = $urandom_range(32);
            msk = AddrW'(64'hFFFF_FFFF_0000_0000 >> len);
          end
        endcase
        gw = ($urandom_range(3) == 0) ? 32'h0 : 32'($urandom);
        add_route($urandom, msk, gw, idle_pct);
      end else begin
        if (held_network.size() > 0 && $urandom_range(9) < 6) begin
          pick = $urandom_range(held_network.size() - 1);
          addr = held_network[pick] | (32'($urandom) & ~held_mask[pick]);
          // near miss on one bit
          if ($urandom_range(4) == 0) addr ^= 32'h1 << $urandom_range(31);
        end else begin
          case ($urandom_range(9))
            0:       addr = 32'h0000_0000;
            1:       addr = 32'hFFFF_FFFF;
            default: addr = $urandom;
          endcase
        end
        lookup(addr, idle_pct);
      end
    end
    start_i <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/rtpm_pkg.sv
design/rtpm_ctrl.sv
design/rtpm_dp.sv
design/route_table_prefix_match_core.sv
tb/route_table_prefix_match_checker.sv
tb/route_table_prefix_match_core_tb.sv
